// ===== rtl/velocity_norm_clamp_smoother_defines.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef VELOCITY_NORM_CLAMP_SMOOTHER_DEFINES_SVH
`define VELOCITY_NORM_CLAMP_SMOOTHER_DEFINES_SVH
// same-cycle implication
`define VNCS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("vncs assertion failed");
// next-cycle implication
`define VNCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("vncs assertion failed");
`endif

// ===== rtl/vncs_pkg.sv =====
// types and constants of the velocity norm clamp smoother
// no dependencies
package vncs_pkg;
    localparam int VEL_W  = 16;
    localparam int LIM_W  = 15;
    localparam int GAIN_W = 16;
    localparam int ACC_W  = VEL_W + 16;

    localparam logic [1:0] OP_CMD   = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] CFG_LIN  = 2'd0;
    localparam logic [1:0] CFG_ANG  = 2'd1;
    localparam logic [1:0] CFG_GAIN = 2'd2;

    localparam logic [LIM_W-1:0]  LIN_RESET  = 15'd2048;
    localparam logic [LIM_W-1:0]  ANG_RESET  = 15'd3072;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd655;

    typedef logic signed [2:0][VEL_W-1:0] t_vec3;

    typedef struct packed {
        logic  done;
        t_vec3 vel;
    } t_lane_res;
endpackage

// ===== rtl/vncs_lane.sv =====
// one vector lane: norm clamp via iterative sqrt and division, then low-pass filter
// depends on vncs_pkg
module vncs_lane import vncs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_clear,
    input  t_vec3             i_tgt,
    input  logic [LIM_W-1:0]  i_limit,
    input  logic [GAIN_W-1:0] i_gain,
    output t_lane_res         o_res
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SQ   = 4'd1;
    localparam logic [3:0] S_ACC  = 4'd2;
    localparam logic [3:0] S_LIM  = 4'd3;
    localparam logic [3:0] S_CMP  = 4'd4;
    localparam logic [3:0] S_SQRT = 4'd5;
    localparam logic [3:0] S_DMUL = 4'd6;
    localparam logic [3:0] S_DLD  = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_DST  = 4'd9;
    localparam logic [3:0] S_SMHI = 4'd10;
    localparam logic [3:0] S_SMLO = 4'd11;
    localparam logic [3:0] S_SMAD = 4'd12;
    localparam logic [3:0] S_DONE = 4'd13;

    logic [3:0]                r_state;
    logic [1:0]                r_idx;
    logic [4:0]                r_cnt;
    logic signed [35:0]        r_prod;
    logic signed [35:0]        r_step;
    logic [31:0]               r_sum;
    logic [31:0]               r_rad;
    logic [15:0]               r_root;
    logic [16:0]               r_rem;
    logic [29:0]               r_dquo;
    logic [15:0]               r_drem;
    t_vec3                     r_clp;
    logic signed [2:0][31:0]   r_s;

    logic [15:0]        w_abs;
    logic               w_neg;
    logic signed [17:0] w_ma;
    logic signed [17:0] w_mb;
    logic signed [35:0] w_mul;
    logic signed [33:0] w_d;
    logic [18:0]        w_srem;
    logic [18:0]        w_strial;
    logic [16:0]        w_drem;
    logic signed [35:0] w_acc;
    logic signed [VEL_W-1:0] w_q;

    assign w_neg = i_tgt[r_idx][VEL_W-1];
    assign w_abs = w_neg ? 16'(-i_tgt[r_idx]) : 16'(i_tgt[r_idx]);
    assign w_d   = {{2{r_clp[r_idx][VEL_W-1]}}, r_clp[r_idx], 16'h0000}
                 - {{2{r_s[r_idx][31]}}, r_s[r_idx]};
    assign w_mul = w_ma * w_mb;
    assign w_srem   = {r_rem, r_rad[31:30]};
    assign w_strial = {1'b0, r_root, 2'b01};
    assign w_drem   = {r_drem, r_dquo[29]};
    assign w_acc    = {{4{r_s[r_idx][31]}}, r_s[r_idx]} + r_step + (r_prod >>> 16);
    assign w_q      = r_dquo[15:0];

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_SQ: begin
                w_ma = {2'b00, w_abs};
                w_mb = {2'b00, w_abs};
            end
            S_LIM: begin
                w_ma = {3'b000, i_limit};
                w_mb = {3'b000, i_limit};
            end
            S_DMUL: begin
                w_ma = {2'b00, w_abs};
                w_mb = {3'b000, i_limit};
            end
            S_SMHI: begin
                w_ma = {2'b00, i_gain};
                w_mb = w_d[33:16];
            end
            S_SMLO: begin
                w_ma = {2'b00, i_gain};
                w_mb = {2'b00, w_d[15:0]};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_s     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (i_clear) begin
                        r_s <= '0;
                    end
                    if (i_start) begin
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_prod  <= w_mul;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sum <= (r_idx == 2'd0) ? r_prod[31:0] : r_sum + r_prod[31:0];
                    if (r_idx == 2'd2) begin
                        r_state <= S_LIM;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_SQ;
                    end
                end
                S_LIM: begin
                    r_prod  <= w_mul;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_idx <= '0;
                    if (r_sum <= r_prod[31:0]) begin
                        r_clp   <= i_tgt;
                        r_state <= S_SMHI;
                    end else begin
                        r_rad   <= r_sum;
                        r_root  <= '0;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (w_srem >= w_strial) begin
                        r_rem  <= 17'(w_srem - w_strial);
                        r_root <= {r_root[14:0], 1'b1};
                    end else begin
                        r_rem  <= 17'(w_srem);
                        r_root <= {r_root[14:0], 1'b0};
                    end
                    r_rad <= {r_rad[29:0], 2'b00};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd15) begin
                        r_state <= S_DMUL;
                    end
                end
                S_DMUL: begin
                    r_prod  <= w_mul;
                    r_state <= S_DLD;
                end
                S_DLD: begin
                    r_dquo  <= r_prod[29:0];
                    r_drem  <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_drem >= {1'b0, r_root}) begin
                        r_drem <= 16'(w_drem - {1'b0, r_root});
                        r_dquo <= {r_dquo[28:0], 1'b1};
                    end else begin
                        r_drem <= w_drem[15:0];
                        r_dquo <= {r_dquo[28:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd29) begin
                        r_state <= S_DST;
                    end
                end
                S_DST: begin
                    r_clp[r_idx] <= w_neg ? -w_q : w_q;
                    if (r_idx == 2'd2) begin
                        r_idx   <= '0;
                        r_state <= S_SMHI;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_DMUL;
                    end
                end
                S_SMHI: begin
                    r_prod  <= w_mul;
                    r_state <= S_SMLO;
                end
                S_SMLO: begin
                    r_step  <= r_prod;
                    r_prod  <= w_mul;
                    r_state <= S_SMAD;
                end
                S_SMAD: begin
                    r_s[r_idx] <= w_acc[31:0];
                    if (r_idx == 2'd2) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_SMHI;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        logic signed [32:0] v_rnd;
        logic signed [16:0] v_r;
        o_res.done = (r_state == S_DONE);
        o_res.vel  = '0;
        for (int i = 0; i < 3; i++) begin
            v_rnd = {r_s[i][31], r_s[i]} + 33'sd32768;
            v_r   = v_rnd[32:16];
            if (v_r > 17'sd32767) begin
                o_res.vel[i] = 16'sh7fff;
            end else if (v_r < -17'sd32768) begin
                o_res.vel[i] = 16'sh8000;
            end else begin
                o_res.vel[i] = v_r[15:0];
            end
        end
    end
endmodule

// ===== rtl/vncs_merge.sv =====
// merge stage: waits for both lanes and holds the result transaction
// depends on vncs_pkg
module vncs_merge import vncs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_lane_res i_lin,
    input  t_lane_res i_ang,
    input  logic      i_out_ready,
    output logic      o_busy,
    output logic      o_out_valid,
    output t_vec3     o_lin,
    output t_vec3     o_ang
);
    logic  r_busy;
    logic  r_dl;
    logic  r_da;
    logic  r_ov;
    t_vec3 r_lin;
    t_vec3 r_ang;
    logic  w_load;

    assign w_load = r_busy && r_dl && r_da && (!r_ov || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_dl   <= 1'b0;
            r_da   <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_dl   <= 1'b0;
                r_da   <= 1'b0;
            end else begin
                if (i_lin.done) r_dl <= 1'b1;
                if (i_ang.done) r_da <= 1'b1;
                if (w_load) r_busy <= 1'b0;
            end
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_lin <= i_lin.vel;
            r_ang <= i_ang.vel;
        end
    end

    assign o_busy      = r_busy;
    assign o_out_valid = r_ov;
    assign o_lin       = r_lin;
    assign o_ang       = r_ang;
endmodule

// ===== rtl/velocity_norm_clamp_smoother.sv =====
// a tick runs squaring, limit compare and low-pass filter steps in each lane; a clamped vector adds a
// 16-step square root plus three 30-step divisions per lane, both lanes in parallel
// one transaction at a time; command and clear transactions do not make the block busy
// synchronous active-low reset: targets and filter state zero, limits and gain to defaults
module velocity_norm_clamp_smoother import vncs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_idx,
    input  logic [15:0]             i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_op,
    input  logic signed [VEL_W-1:0] i_cmd_lin_x,
    input  logic signed [VEL_W-1:0] i_cmd_lin_y,
    input  logic signed [VEL_W-1:0] i_cmd_lin_z,
    input  logic signed [VEL_W-1:0] i_cmd_ang_x,
    input  logic signed [VEL_W-1:0] i_cmd_ang_y,
    input  logic signed [VEL_W-1:0] i_cmd_ang_z,
    input  logic [5:0]              i_nonfinite_mask,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [VEL_W-1:0] o_out_lin_x,
    output logic signed [VEL_W-1:0] o_out_lin_y,
    output logic signed [VEL_W-1:0] o_out_lin_z,
    output logic signed [VEL_W-1:0] o_out_ang_x,
    output logic signed [VEL_W-1:0] o_out_ang_y,
    output logic signed [VEL_W-1:0] o_out_ang_z
);
    logic [LIM_W-1:0]  r_lin_lim;
    logic [LIM_W-1:0]  r_ang_lim;
    logic [GAIN_W-1:0] r_gain;
    t_vec3             r_tlin;
    t_vec3             r_tang;
    logic              w_acc;
    logic              w_busy;
    logic              w_start;
    logic              w_clear;
    t_lane_res         w_lin_res;
    t_lane_res         w_ang_res;
    t_vec3             w_olin;
    t_vec3             w_oang;

    function automatic logic signed [VEL_W-1:0] neg_sat(input logic signed [VEL_W-1:0] v);
        return (v == {1'b1, {(VEL_W-1){1'b0}}}) ? {1'b0, {(VEL_W-1){1'b1}}} : -v;
    endfunction

    assign o_in_ready = !w_busy;
    assign w_acc      = i_in_valid && !w_busy;
    assign w_start    = w_acc && (i_op == OP_TICK);
    assign w_clear    = w_acc && (i_op == OP_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lin_lim <= LIN_RESET;
            r_ang_lim <= ANG_RESET;
            r_gain    <= GAIN_RESET;
            r_tlin    <= '0;
            r_tang    <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LIN:  r_lin_lim <= i_cfg_data[LIM_W-1:0];
                    CFG_ANG:  r_ang_lim <= i_cfg_data[LIM_W-1:0];
                    CFG_GAIN: r_gain    <= i_cfg_data;
                    default:  r_gain    <= r_gain;
                endcase
            end
            if (w_acc && (i_op == OP_CMD)) begin
                r_tlin[0] <= i_nonfinite_mask[0] ? '0 : i_cmd_lin_x;
                r_tlin[1] <= i_nonfinite_mask[1] ? '0 : neg_sat(i_cmd_lin_y);
                r_tlin[2] <= i_nonfinite_mask[2] ? '0 : neg_sat(i_cmd_lin_z);
                r_tang[0] <= i_nonfinite_mask[3] ? '0 : i_cmd_ang_x;
                r_tang[1] <= i_nonfinite_mask[4] ? '0 : neg_sat(i_cmd_ang_y);
                r_tang[2] <= i_nonfinite_mask[5] ? '0 : neg_sat(i_cmd_ang_z);
            end else if (w_clear) begin
                r_tlin <= '0;
                r_tang <= '0;
            end
        end
    end

    vncs_lane u_lin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_clear (w_clear),
        .i_tgt   (r_tlin),
        .i_limit (r_lin_lim),
        .i_gain  (r_gain),
        .o_res   (w_lin_res)
    );

    vncs_lane u_ang (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_clear (w_clear),
        .i_tgt   (r_tang),
        .i_limit (r_ang_lim),
        .i_gain  (r_gain),
        .o_res   (w_ang_res)
    );

    vncs_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_lin       (w_lin_res),
        .i_ang       (w_ang_res),
        .i_out_ready (i_out_ready),
        .o_busy      (w_busy),
        .o_out_valid (o_out_valid),
        .o_lin       (w_olin),
        .o_ang       (w_oang)
    );

    assign o_out_lin_x = w_olin[0];
    assign o_out_lin_y = w_olin[1];
    assign o_out_lin_z = w_olin[2];
    assign o_out_ang_x = w_oang[0];
    assign o_out_ang_y = w_oang[1];
    assign o_out_ang_z = w_oang[2];
endmodule

// ===== rtl/vncs_checker.sv =====
// port-level checker for the velocity norm clamp smoother, bound to the top level
// depends on vncs_pkg and velocity_norm_clamp_smoother_defines.svh
`include "velocity_norm_clamp_smoother_defines.svh"
module vncs_checker import vncs_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_op,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [15:0] o_out_lin_x,
    input logic [15:0] o_out_ang_z
);
    logic w_stall;
    logic w_tick;

    assign w_stall = o_out_valid && !i_out_ready;
    assign w_tick  = i_in_valid && o_in_ready && (i_op == OP_TICK);

    `VNCS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, o_out_valid)
    `VNCS_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, w_stall, $stable({o_out_lin_x, o_out_ang_z}))
    `VNCS_ASSERT_NEXT(a_tick_busy, i_clk, i_rst_n, w_tick, !o_in_ready)
    `VNCS_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, o_in_ready && !o_out_valid, !o_out_valid)
endmodule

bind velocity_norm_clamp_smoother vncs_checker u_vncs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_op        (i_op),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_lin_x (o_out_lin_x),
    .o_out_ang_z (o_out_ang_z)
);
